/* rtl/eau_pkg.sv */
// shared types, codes and helpers for the effective address unit
package eau_pkg;

	localparam int DATA_W = 32;
	localparam int RF_DEPTH = 16;
	localparam int RF_AW = $clog2(RF_DEPTH);

	// command codes
	localparam logic [1:0] CMD_EA   = 2'd0;
	localparam logic [1:0] CMD_WR_A = 2'd1;
	localparam logic [1:0] CMD_WR_D = 2'd2;

	// addressing mode field
	localparam logic [2:0] MODE_AN_IND  = 3'd2;
	localparam logic [2:0] MODE_POSTINC = 3'd3;
	localparam logic [2:0] MODE_PREDEC  = 3'd4;
	localparam logic [2:0] MODE_DISP    = 3'd5;
	localparam logic [2:0] MODE_INDEX   = 3'd6;
	localparam logic [2:0] MODE_SPECIAL = 3'd7;

	// register field under the special mode
	localparam logic [2:0] SPC_ABS_SHORT = 3'd0;
	localparam logic [2:0] SPC_ABS_LONG  = 3'd1;
	localparam logic [2:0] SPC_PC_DISP   = 3'd2;
	localparam logic [2:0] SPC_PC_INDEX  = 3'd3;

	// register file control, sequencer to register file
	typedef struct packed {
		logic              we;
		logic [RF_AW-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [RF_AW-1:0]  raddr;
	} rf_ctrl_t;

	function automatic logic [DATA_W-1:0] sext16(input logic [15:0] v);
		return {{(DATA_W-16){v[15]}}, v};
	endfunction

	function automatic logic [DATA_W-1:0] sext8(input logic [7:0] v);
		return {{(DATA_W-8){v[7]}}, v};
	endfunction

endpackage

/* rtl/eau_regfile.sv */
// address and data register file: one write port, one registered read port
module eau_regfile (
	input  logic                             clk,
	input  logic                             arst_n,
	input  eau_pkg::rf_ctrl_t                ctrl,
	output logic [eau_pkg::DATA_W-1:0]       rdata
);

	logic [eau_pkg::DATA_W-1:0]   mem [eau_pkg::RF_DEPTH];
	logic [eau_pkg::RF_DEPTH-1:0] vld_q;
	logic [eau_pkg::DATA_W-1:0]   rdata_q;

	// storage array, address registers low, data registers high
	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[ctrl.waddr] <= ctrl.wdata;
		end
	end

	// written flags, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctrl.we) begin
			vld_q[ctrl.waddr] <= 1'b1;
		end
	end

	// registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (ctrl.re) begin
			rdata_q <= vld_q[ctrl.raddr] ? mem[ctrl.raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/effective_address_unit.sv */
// effective address unit: sequencer, shared adder and result registers
//
// Usage: drive command and its operand ports and raise start while busy is
// low; the beat is taken at that edge. Command 1 or 2 loads write_value into
// address or data register reg_num; command 0 forms the effective address
// for mode and reg_num, stepping An for postincrement and predecrement.
// One result beat per command: done is high for exactly one cycle with
// eff_addr, ea_valid and base_after. eff_addr is zero when ea_valid is low.
// busy stays high from the accepting edge until done is shown, so no new
// command is taken while one is in progress. A register write passes a
// write step before the steps of a compute command. The sequence is set by
// the single read port of the register file (base, then index register) and
// the one 32-bit adder used twice (displacement, then index).
// A new command may be accepted in the cycle in which done is shown.
// Reset makes all sixteen registers read as zero, returns the sequencer to
// idle. The receiver cannot stall; each result must be taken when shown.
module effective_address_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 command,
	input  logic [2:0]                 mode,
	input  logic [2:0]                 reg_num,
	input  logic [2:0]                 op_size,
	input  logic [15:0]                ext_word,
	input  logic [31:0]                abs_long,
	input  logic [31:0]                pc,
	input  logic [31:0]                write_value,
	output logic                       done,
	output logic [31:0]                eff_addr,
	output logic                       ea_valid,
	output logic [31:0]                base_after
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_RD_BASE,
		S_RD_INDEX,
		S_CALC1,
		S_CALC2,
		S_FINISH
	} state_t;

	state_t                     state_q;
	logic [1:0]                 cmd_q;
	logic [2:0]                 mode_q;
	logic [2:0]                 rn_q;
	logic [2:0]                 size_q;
	logic [15:0]                ext_q;
	logic [31:0]                absl_q;
	logic [31:0]                pc_q;
	logic [31:0]                wval_q;
	logic [31:0]                base_q;
	logic [31:0]                acc_q;
	logic                       done_q;
	logic [31:0]                eff_addr_q;
	logic                       ea_valid_q;
	logic [31:0]                base_after_q;

	eau_pkg::rf_ctrl_t          rf_ctrl;
	logic [31:0]                rf_rdata;

	logic                       is_index;
	logic                       is_step;
	logic                       ea_ok;
	logic [31:0]                xn;
	logic [31:0]                add_a;
	logic [31:0]                add_b;
	logic                       add_sub;
	logic [31:0]                add_sum;
	logic [31:0]                ea_sel;

	eau_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rf_ctrl),
		.rdata  (rf_rdata)
	);

	// decode of the held command
	always_comb begin
		is_index = (mode_q == eau_pkg::MODE_INDEX) ||
			((mode_q == eau_pkg::MODE_SPECIAL) && (rn_q == eau_pkg::SPC_PC_INDEX));
		is_step  = (cmd_q == eau_pkg::CMD_EA) &&
			((mode_q == eau_pkg::MODE_POSTINC) || (mode_q == eau_pkg::MODE_PREDEC));
		ea_ok = 1'b0;
		if (cmd_q == eau_pkg::CMD_EA) begin
			case (mode_q)
				eau_pkg::MODE_AN_IND, eau_pkg::MODE_POSTINC, eau_pkg::MODE_PREDEC,
				eau_pkg::MODE_DISP, eau_pkg::MODE_INDEX: begin
					ea_ok = 1'b1;
				end
				eau_pkg::MODE_SPECIAL: begin
					ea_ok = (rn_q == eau_pkg::SPC_ABS_SHORT) ||
						(rn_q == eau_pkg::SPC_ABS_LONG) ||
						(rn_q == eau_pkg::SPC_PC_DISP) ||
						(rn_q == eau_pkg::SPC_PC_INDEX);
				end
				default: begin
					ea_ok = 1'b0;
				end
			endcase
		end
	end

	// index register, word form sign-extended
	assign xn = ext_q[11] ? rf_rdata : eau_pkg::sext16(rf_rdata[15:0]);

	// operand selection for the shared adder
	always_comb begin
		add_a   = base_q;
		add_b   = '0;
		add_sub = 1'b0;
		if (state_q == S_CALC2) begin
			add_a = acc_q;
			add_b = is_index ? xn : '0;
		end else begin
			case (mode_q)
				eau_pkg::MODE_POSTINC: begin
					add_b = {29'd0, size_q};
				end
				eau_pkg::MODE_PREDEC: begin
					add_b   = {29'd0, size_q};
					add_sub = 1'b1;
				end
				eau_pkg::MODE_DISP: begin
					add_b = eau_pkg::sext16(ext_q);
				end
				eau_pkg::MODE_INDEX: begin
					add_b = eau_pkg::sext8(ext_q[7:0]);
				end
				eau_pkg::MODE_SPECIAL: begin
					case (rn_q)
						eau_pkg::SPC_ABS_SHORT: begin
							add_a = '0;
							add_b = eau_pkg::sext16(ext_q);
						end
						eau_pkg::SPC_ABS_LONG: begin
							add_a = absl_q;
						end
						eau_pkg::SPC_PC_DISP: begin
							add_a = pc_q;
							add_b = eau_pkg::sext16(ext_q);
						end
						eau_pkg::SPC_PC_INDEX: begin
							add_a = pc_q;
							add_b = eau_pkg::sext8(ext_q[7:0]);
						end
						default: begin
							add_a = '0;
						end
					endcase
				end
				default: begin
					add_b = '0;
				end
			endcase
		end
	end

	// the one adder, subtract by inverted operand and carry in
	assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {31'd0, add_sub};

	// address is the old base for postincrement, the sum otherwise
	assign ea_sel = (mode_q == eau_pkg::MODE_POSTINC) ? base_q : acc_q;

	// register file control from the sequencer state
	always_comb begin
		rf_ctrl.we    = 1'b0;
		rf_ctrl.waddr = {1'b0, rn_q};
		rf_ctrl.wdata = acc_q;
		rf_ctrl.re    = 1'b0;
		rf_ctrl.raddr = {1'b0, rn_q};
		case (state_q)
			S_WRITE: begin
				rf_ctrl.we    = 1'b1;
				rf_ctrl.waddr = {cmd_q == eau_pkg::CMD_WR_D, rn_q};
				rf_ctrl.wdata = wval_q;
			end
			S_RD_BASE: begin
				rf_ctrl.re = 1'b1;
			end
			S_RD_INDEX: begin
				rf_ctrl.re    = 1'b1;
				rf_ctrl.raddr = {~ext_q[15], ext_q[14:12]};
			end
			S_CALC2: begin
				rf_ctrl.we = is_step;
			end
			default: begin
				rf_ctrl.we = 1'b0;
			end
		endcase
	end

	// sequencer, working registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			cmd_q        <= '0;
			mode_q       <= '0;
			rn_q         <= '0;
			size_q       <= '0;
			ext_q        <= '0;
			absl_q       <= '0;
			pc_q         <= '0;
			wval_q       <= '0;
			base_q       <= '0;
			acc_q        <= '0;
			eff_addr_q   <= '0;
			ea_valid_q   <= 1'b0;
			base_after_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q  <= command;
						mode_q <= mode;
						rn_q   <= reg_num;
						size_q <= op_size;
						ext_q  <= ext_word;
						absl_q <= abs_long;
						pc_q   <= pc;
						wval_q <= write_value;
						if ((command == eau_pkg::CMD_WR_A) || (command == eau_pkg::CMD_WR_D)) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_RD_BASE;
						end
					end
				end
				S_WRITE: begin
					state_q <= S_RD_BASE;
				end
				S_RD_BASE: begin
					state_q <= S_RD_INDEX;
				end
				S_RD_INDEX: begin
					base_q  <= rf_rdata;
					state_q <= S_CALC1;
				end
				S_CALC1: begin
					acc_q   <= add_sum;
					state_q <= S_CALC2;
				end
				S_CALC2: begin
					acc_q   <= add_sum;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					done_q       <= 1'b1;
					ea_valid_q   <= ea_ok;
					eff_addr_q   <= ea_ok ? ea_sel : '0;
					base_after_q <= is_step ? acc_q : base_q;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign eff_addr   = eff_addr_q;
	assign ea_valid   = ea_valid_q;
	assign base_after = base_after_q;

	// a result beat only follows the finishing step
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FINISH))
		else $error("result beat without finishing step");

	// no address reported for a non-memory form
	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ea_valid) |-> (eff_addr == '0))
		else $error("address reported without valid flag");

	// register file written only by a write command or an address step
	a_rf_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		rf_ctrl.we |-> ((state_q == S_WRITE) || ((state_q == S_CALC2) && is_step)))
		else $error("unexpected register file write");

	// sequencer never leaves idle without an accepted command
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && !start) |=> (state_q == S_IDLE))
		else $error("sequencer started without a command");

endmodule

/* dv/effective_address_unit_tb.sv */
// self-checking testbench for the effective address unit
`timescale 1ns / 100ps

module effective_address_unit_tb;

	// codes the package leaves out
	localparam logic [1:0] CMD_UNUSED     = 2'd3;
	localparam logic [2:0] MODE_DN_DIRECT = 3'd0;
	localparam logic [2:0] MODE_AN_DIRECT = 3'd1;
	localparam logic [2:0] SPC_IMMEDIATE  = 3'd4;

	localparam int RANDOM_BEATS = 1950;
	localparam int QUIET_LIMIT  = 2000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  mode;
		logic [2:0]  reg_num;
		logic [2:0]  op_size;
		logic [15:0] ext_word;
		logic [31:0] abs_long;
		logic [31:0] pc;
		logic [31:0] write_value;
	} ea_cmd_t;

	typedef struct packed {
		logic [31:0] eff_addr;
		logic        ea_valid;
		logic [31:0] base_after;
	} ea_result_t;

	// register file mirror and queue of addresses still to come
	class ea_tracker;
		logic [31:0] addr_regs [8];
		logic [31:0] data_regs [8];
		ea_result_t  pending_ea [$];
		int unsigned errors;

		function new();
			for (int i = 0; i < 8; i++) begin
				addr_regs[i] = '0;
				data_regs[i] = '0;
			end
			errors = 0;
		endfunction

		function logic [31:0] widen_word(logic [15:0] v);
			return {{16{v[15]}}, v};
		endfunction

		// brief word: bit 15 picks A or D, bits 14..12 the register, bit 11 long index
		function logic [31:0] index_offset(logic [15:0] ext);
			logic [31:0] xn;
			xn = ext[15] ? addr_regs[ext[14:12]] : data_regs[ext[14:12]];
			if (!ext[11])
				xn = widen_word(xn[15:0]);
			return {{24{ext[7]}}, ext[7:0]} + xn;
		endfunction

		function void note_command(ea_cmd_t c);
			ea_result_t  r;
			logic [31:0] an;
			logic [31:0] step;
			r = '0;
			an = addr_regs[c.reg_num];
			step = {29'd0, c.op_size};
			case (c.command)
				eau_pkg::CMD_WR_A: addr_regs[c.reg_num] = c.write_value;
				eau_pkg::CMD_WR_D: data_regs[c.reg_num] = c.write_value;
				eau_pkg::CMD_EA: begin
					r.ea_valid = 1'b1;
					case (c.mode)
						eau_pkg::MODE_AN_IND: r.eff_addr = an;
						eau_pkg::MODE_POSTINC: begin
							r.eff_addr = an;
							addr_regs[c.reg_num] = an + step;
						end
						eau_pkg::MODE_PREDEC: begin
							addr_regs[c.reg_num] = an - step;
							r.eff_addr = an - step;
						end
						eau_pkg::MODE_DISP: r.eff_addr = an + widen_word(c.ext_word);
						eau_pkg::MODE_INDEX: r.eff_addr = an + index_offset(c.ext_word);
						eau_pkg::MODE_SPECIAL: begin
							case (c.reg_num)
								eau_pkg::SPC_ABS_SHORT: r.eff_addr = widen_word(c.ext_word);
								eau_pkg::SPC_ABS_LONG: r.eff_addr = c.abs_long;
								eau_pkg::SPC_PC_DISP:
									r.eff_addr = c.pc + widen_word(c.ext_word);
								eau_pkg::SPC_PC_INDEX:
									r.eff_addr = c.pc + index_offset(c.ext_word);
								default: r.ea_valid = 1'b0;
							endcase
						end
						default: r.ea_valid = 1'b0;
					endcase
				end
				default: ;
			endcase
			r.base_after = addr_regs[c.reg_num];
			pending_ea.push_back(r);
		endfunction

		function void check_result(ea_result_t got);
			ea_result_t want;
			if (pending_ea.size() == 0) begin
				if (errors < REPORT_LIMIT)
					$display("%0t: result beat with nothing outstanding: ea %h valid %b base %h",
						$time, got.eff_addr, got.ea_valid, got.base_after);
				errors++;
				return;
			end
			want = pending_ea.pop_front();
			if (got !== want) begin
				if (errors < REPORT_LIMIT) begin
					$display("%0t: mismatch", $time);
					if (got.eff_addr !== want.eff_addr)
						$display("  eff_addr   expected %h got %h", want.eff_addr, got.eff_addr);
					if (got.ea_valid !== want.ea_valid)
						$display("  ea_valid   expected %b got %b", want.ea_valid, got.ea_valid);
					if (got.base_after !== want.base_after)
						$display("  base_after expected %h got %h", want.base_after, got.base_after);
				end
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        busy;
	logic [1:0]  command     = '0;
	logic [2:0]  mode        = '0;
	logic [2:0]  reg_num     = '0;
	logic [2:0]  op_size     = '0;
	logic [15:0] ext_word    = '0;
	logic [31:0] abs_long    = '0;
	logic [31:0] pc          = '0;
	logic [31:0] write_value = '0;
	logic        done;
	logic [31:0] eff_addr;
	logic        ea_valid;
	logic [31:0] base_after;

	ea_tracker   tracker;
	int unsigned quiet_cycles = 0;

	effective_address_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.mode        (mode),
		.reg_num     (reg_num),
		.op_size     (op_size),
		.ext_word    (ext_word),
		.abs_long    (abs_long),
		.pc          (pc),
		.write_value (write_value),
		.done        (done),
		.eff_addr    (eff_addr),
		.ea_valid    (ea_valid),
		.base_after  (base_after)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result beats are shown for one cycle and taken at the edge that ends it
	always @(posedge clk) begin
		ea_result_t got;
		if (arst_n && done === 1'b1) begin
			got = '{eff_addr: eff_addr, ea_valid: ea_valid, base_after: base_after};
			tracker.check_result(got);
		end
	end

	// cycles without any beat in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("effective_address_unit_tb: errors");
		$finish;
	end

	// hold a command on the ports until the block takes it
	task automatic run_beat(ea_cmd_t c);
		start       <= 1'b1;
		command     <= c.command;
		mode        <= c.mode;
		reg_num     <= c.reg_num;
		op_size     <= c.op_size;
		ext_word    <= c.ext_word;
		abs_long    <= c.abs_long;
		pc          <= c.pc;
		write_value <= c.write_value;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_command(c);
	endtask

	task automatic hold_off(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender waits until every address has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending_ea.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_long();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'(($urandom_range(0, 1) ? 32'hFFFF_0000 : 32'h0000_0000)
				| $urandom_range(0, 16'hFFFF));
			default: return $urandom;
		endcase
	endfunction

	function automatic ea_cmd_t shaped(logic [1:0] cmd, logic [2:0] md, logic [2:0] rn,
			logic [2:0] size, logic [15:0] ext);
		ea_cmd_t c;
		c.command     = cmd;
		c.mode        = md;
		c.reg_num     = rn;
		c.op_size     = size;
		c.ext_word    = ext;
		c.abs_long    = $urandom;
		c.pc          = $urandom;
		c.write_value = $urandom;
		return c;
	endfunction

	function automatic logic [15:0] brief_word(bit is_addr, logic [2:0] xr, bit is_long,
			logic [7:0] disp);
		return {is_addr, xr, is_long, 3'b000, disp};
	endfunction

	// mostly memory modes with normal sizes, plus register loads and some noise
	function automatic ea_cmd_t random_command();
		ea_cmd_t     c;
		int unsigned pick;
		c = shaped(eau_pkg::CMD_EA, 3'($urandom_range(2, 7)), 3'($urandom), 3'($urandom),
			16'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 18)
			c.command = eau_pkg::CMD_WR_A;
		else if (pick < 30)
			c.command = eau_pkg::CMD_WR_D;
		else if (pick < 33)
			c.command = CMD_UNUSED;
		c.write_value = pick_long();
		c.pc = pick_long();
		c.abs_long = pick_long();
		if ($urandom_range(0, 9) == 0)
			c.mode = 3'($urandom);
		if (c.mode == eau_pkg::MODE_SPECIAL && $urandom_range(0, 4) != 0)
			c.reg_num = 3'($urandom_range(0, 3));
		if ($urandom_range(0, 9) < 8) begin
			case ($urandom_range(0, 2))
				0: c.op_size = 3'd1;
				1: c.op_size = 3'd2;
				default: c.op_size = 3'd4;
			endcase
		end
		return c;
	endfunction

	initial begin
		ea_cmd_t     c;
		int unsigned sent;
		int unsigned burst;
		bit          drained;
		tracker = new();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// predecrement below zero then postincrement across the wrap
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_PREDEC, 3'd0, 3'd1, 16'h0000));
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_POSTINC, 3'd0, 3'd4, 16'hFFFF));
		// stack pointer steps by one on byte operands
		c = shaped(eau_pkg::CMD_WR_A, eau_pkg::MODE_AN_IND, 3'd7, 3'd2, 16'h0000);
		c.write_value = 32'h0000_1001;
		run_beat(c);
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_POSTINC, 3'd7, 3'd1, 16'h0000));
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_PREDEC, 3'd7, 3'd1, 16'h0000));
		// index registers with the sign bit set in the long or in the low word
		c = shaped(eau_pkg::CMD_WR_D, MODE_DN_DIRECT, 3'd5, 3'd4, 16'h0000);
		c.write_value = 32'h8000_7FFF;
		run_beat(c);
		c = shaped(eau_pkg::CMD_WR_A, MODE_AN_DIRECT, 3'd3, 3'd4, 16'h0000);
		c.write_value = 32'hFFFF_8000;
		run_beat(c);
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_INDEX, 3'd7, 3'd2,
			brief_word(0, 3'd5, 0, 8'h80)));
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_INDEX, 3'd7, 3'd2,
			brief_word(0, 3'd5, 1, 8'h7F)));
		c = shaped(eau_pkg::CMD_EA, eau_pkg::MODE_SPECIAL, eau_pkg::SPC_PC_INDEX, 3'd2,
			brief_word(1, 3'd3, 0, 8'hFF));
		c.pc = 32'hFFFF_FFF0;
		run_beat(c);
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_SPECIAL, eau_pkg::SPC_PC_INDEX, 3'd2,
			brief_word(1, 3'd3, 1, 8'h00)));
		// displacement extremes
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_DISP, 3'd3, 3'd2, 16'h8000));
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_DISP, 3'd3, 3'd2, 16'h7FFF));
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_AN_IND, 3'd3, 3'd2, 16'h0000));
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_SPECIAL, eau_pkg::SPC_ABS_SHORT, 3'd2,
			16'hFFFF));
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_SPECIAL, eau_pkg::SPC_ABS_SHORT, 3'd2,
			16'h7FFF));
		c = shaped(eau_pkg::CMD_EA, eau_pkg::MODE_SPECIAL, eau_pkg::SPC_ABS_LONG, 3'd4,
			16'h0000);
		c.abs_long = 32'hFFFF_FFFF;
		run_beat(c);
		c = shaped(eau_pkg::CMD_EA, eau_pkg::MODE_SPECIAL, eau_pkg::SPC_PC_DISP, 3'd4,
			16'h8000);
		c.pc = 32'h0000_0000;
		run_beat(c);
		// immediate and the unused special registers
		for (int k = 0; k < 4; k++)
			run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_SPECIAL, SPC_IMMEDIATE + 3'(k),
				3'd4, 16'($urandom)));
		// register direct modes, the unused command and odd sizes
		run_beat(shaped(eau_pkg::CMD_EA, MODE_DN_DIRECT, 3'd3, 3'd4, 16'hFFFF));
		run_beat(shaped(eau_pkg::CMD_EA, MODE_AN_DIRECT, 3'd3, 3'd4, 16'hFFFF));
		run_beat(shaped(CMD_UNUSED, eau_pkg::MODE_POSTINC, 3'd3, 3'd4, 16'hFFFF));
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_POSTINC, 3'd3, 3'd7, 16'h0000));
		run_beat(shaped(eau_pkg::CMD_EA, eau_pkg::MODE_PREDEC, 3'd3, 3'd0, 16'h0000));
		drain();

		// random bursts with random gaps between them
		sent = 0;
		drained = 0;
		while (sent < RANDOM_BEATS) begin
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				run_beat(random_command());
				sent++;
			end
			if (!drained && sent >= RANDOM_BEATS / 2) begin
				drain();
				drained = 1;
			end else if ($urandom_range(0, 3) != 0) begin
				hold_off($urandom_range(1, 12));
			end
		end

		drain();
		repeat (12) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_ea.size() == 0)
			$display("effective_address_unit_tb: clean");
		else
			$display("effective_address_unit_tb: errors");
		$finish;
	end

endmodule

/* files.f */
rtl/eau_pkg.sv
rtl/eau_regfile.sv
rtl/effective_address_unit.sv
dv/effective_address_unit_tb.sv
